### rtl/assert_macros.svh
// assertion macros shared by the rtl of the binomial coefficient unit
// every macro expects clk and rst (synchronous, active high) in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bci_pkg.sv
// shared types for the binomial coefficient unit
// used by bci_shared_unit and binomial_coefficient_iterative_unit, no dependencies
package bci_pkg;

  // operation of the shared multiply/divide unit
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  // command from the sequencer to the shared unit
  typedef struct packed {
    logic start;
    op_t  op;
  } unit_cmd_t;

  // status from the shared unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

### rtl/bci_req_if.sv
// request channel of the binomial coefficient unit: valid/ready plus n and k
// no dependencies
interface bci_req_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] total_items;
  logic [DATA_WIDTH-1:0] group_size;

  modport source (output valid, output total_items, output group_size, input ready);
  modport sink   (input valid, input total_items, input group_size, output ready);
endinterface

### rtl/bci_rsp_if.sv
// response channel of the binomial coefficient unit: valid/ready plus the result
// no dependencies
interface bci_rsp_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] combinations;

  modport source (output valid, output combinations, input ready);
  modport sink   (input valid, input combinations, output ready);
endinterface

### rtl/bci_shared_unit.sv
// bit-serial multiply (low half) and restoring divide on one shared adder
// one bit per cycle; uses bci_pkg, assert_macros.svh
`include "assert_macros.svh"

module bci_shared_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bci_pkg::unit_cmd_t      cmd,
  input  logic [DATA_WIDTH-1:0]   opa,
  input  logic [DATA_WIDTH-1:0]   opb,
  output bci_pkg::unit_sts_t      sts,
  output logic [DATA_WIDTH-1:0]   result
);

  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] LAST_STEP = CW'(DATA_WIDTH - 1);

  logic                  busy;
  logic                  done;
  logic [CW-1:0]         cnt;
  bci_pkg::op_t          op;
  logic [DATA_WIDTH-1:0] acc;   // product or partial remainder
  logic [DATA_WIDTH-1:0] sh;    // multiplier bits out, quotient bits in
  logic [DATA_WIDTH-1:0] opnd;  // multiplicand or divisor

  logic [DATA_WIDTH:0]   add_x;
  logic [DATA_WIDTH:0]   add_y;
  logic                  add_sub;
  logic [DATA_WIDTH+1:0] add_sum;
  logic                  neg;

  always_comb begin
    if (op == bci_pkg::OP_MUL) begin
      // msb-first shift-add, only the low half is kept
      add_x   = {1'b0, acc[DATA_WIDTH-2:0], 1'b0};
      add_y   = sh[DATA_WIDTH-1] ? {1'b0, opnd} : '0;
      add_sub = 1'b0;
    end else begin
      add_x   = {acc, sh[DATA_WIDTH-1]};
      add_y   = {1'b0, opnd};
      add_sub = 1'b1;
    end
    add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(DATA_WIDTH+2){add_sub}})
              + (DATA_WIDTH+2)'(add_sub);
    neg     = add_sum[DATA_WIDTH+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !cmd.start && busy && (cnt == LAST_STEP);
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op   <= cmd.op;
      acc  <= '0;
      sh   <= opa;
      opnd <= opb;
    end else if (busy) begin
      sh <= {sh[DATA_WIDTH-2:0], (op == bci_pkg::OP_DIV) && !neg};
      if (op == bci_pkg::OP_DIV && neg) begin
        // restore: shifted remainder stays below the divisor
        acc <= add_x[DATA_WIDTH-1:0];
      end else begin
        acc <= add_sum[DATA_WIDTH-1:0];
      end
    end
  end

  assign result = (op == bci_pkg::OP_MUL) ? acc : sh;
  assign sts    = '{busy: busy, done: done};

  `ASSERT_IMPLIES(a_start_when_free, cmd.start, !busy, "start while unit busy")
  `ASSERT_NEXT(a_start_sets_busy, cmd.start, busy, "unit did not start")
  `ASSERT_IMPLIES(a_done_after_busy, done, !busy, "done raised while still busy")

endmodule

### rtl/binomial_coefficient_iterative_unit.sv
// n choose k by the multiplicative formula, products wrapped to DATA_WIDTH bits
// k > n, k == 0 and k == 1 are answered without the shared unit; otherwise the unit
//   runs up to k-1 passes (stops early when the running value hits zero)
// each pass is one bit-serial multiply and one bit-serial divide on the shared adder
// ready only while idle, so one request at a time; result in an output register
// reset (rst, synchronous) returns to idle and drops the output valid
`include "assert_macros.svh"

module binomial_coefficient_iterative_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  bci_req_if.sink req,
  bci_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                state;
  logic [DATA_WIDTH-1:0] k_val;
  logic [DATA_WIDTH-1:0] i_val;  // current divisor
  logic [DATA_WIDTH-1:0] fac;    // current factor n - i + 1
  logic [DATA_WIDTH-1:0] res;
  logic                  rsp_valid;
  logic [DATA_WIDTH-1:0] rsp_data;

  bci_pkg::unit_cmd_t    cmd;
  bci_pkg::unit_sts_t    sts;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic [DATA_WIDTH-1:0] unit_res;

  logic                  accept;
  logic                  k_gt_n;
  logic                  k_zero;
  logic                  k_one;
  logic                  finish;
  logic                  load_rsp;

  assign accept   = req.valid && req.ready;
  assign k_gt_n   = req.group_size > req.total_items;
  assign k_zero   = req.group_size == '0;
  assign k_one    = req.group_size == DATA_WIDTH'(1);
  assign finish   = (unit_res == '0) || (i_val == k_val);
  assign load_rsp = (state == ST_DONE) && (!rsp_valid || rsp.ready);

  bci_shared_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_unit (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .opa    (opa),
    .opb    (opb),
    .sts    (sts),
    .result (unit_res)
  );

  // unit commands are issued on the cycle of the transition
  always_comb begin
    cmd = '{start: 1'b0, op: bci_pkg::OP_MUL};
    opa = unit_res;
    opb = fac - DATA_WIDTH'(1);
    unique case (state)
      ST_IDLE: begin
        opa = req.total_items;
        opb = req.total_items - DATA_WIDTH'(1);
        if (accept && !k_gt_n && !k_zero && !k_one) begin
          cmd = '{start: 1'b1, op: bci_pkg::OP_MUL};
        end
      end
      ST_MUL: begin
        opb = i_val;
        if (sts.done) begin
          cmd = '{start: 1'b1, op: bci_pkg::OP_DIV};
        end
      end
      ST_DIV: begin
        if (sts.done && !finish) begin
          cmd = '{start: 1'b1, op: bci_pkg::OP_MUL};
        end
      end
      ST_DONE: begin
        cmd = '{start: 1'b0, op: bci_pkg::OP_MUL};
      end
      default: begin
        cmd = '{start: 1'b0, op: bci_pkg::OP_MUL};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (k_gt_n || k_zero || k_one) begin
              state <= ST_DONE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (sts.done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (sts.done) begin
            state <= finish ? ST_DONE : ST_MUL;
          end
        end
        ST_DONE: begin
          // wait for the output register to free up
          if (load_rsp) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      k_val <= req.group_size;
      i_val <= DATA_WIDTH'(2);
      fac   <= req.total_items - DATA_WIDTH'(1);
      if (k_gt_n) begin
        res <= '0;
      end else if (k_zero) begin
        res <= DATA_WIDTH'(1);
      end else begin
        res <= req.total_items;
      end
    end else if (state == ST_DIV && sts.done) begin
      res <= unit_res;
      if (!finish) begin
        i_val <= i_val + DATA_WIDTH'(1);
        fac   <= fac - DATA_WIDTH'(1);
      end
    end
    if (load_rsp) begin
      rsp_data <= res;
    end
  end

  assign req.ready        = state == ST_IDLE;
  assign rsp.valid        = rsp_valid;
  assign rsp.combinations = rsp_data;

  `ASSERT_IMPLIES(a_done_in_op, sts.done, (state == ST_MUL) || (state == ST_DIV), "stray done")
  `ASSERT_IMPLIES(a_idle_unit_quiet, state == ST_IDLE, !sts.busy, "unit busy while idle")
  `ASSERT_NEXT(a_accept_leaves_idle, accept, state != ST_IDLE, "transfer did not start work")

endmodule

### bench/bci_result_checker.sv
// result checker for the binomial coefficient unit: watches both channels,
// predicts n choose k for each request transfer and compares every result transfer
// depends on the bci_req_if and bci_rsp_if interfaces
module bci_result_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  bci_req_if   req,
  bci_rsp_if   rsp,
  output int   failures,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct {
    word_t total_items;
    word_t group_size;
    word_t combinations;
  } choose_due_t;

  choose_due_t combos_due[$];

  // multiplicative formula, every product wrapped to the data width
  function automatic word_t wrapped_choose(word_t n, word_t k);
    word_t                 acc;
    word_t                 factor;
    word_t                 i;
    logic [2*DATA_WIDTH-1:0] prod;
    if (k > n) return '0;
    if (k == '0) return word_t'(1);
    acc = n;
    if (k == word_t'(1)) return acc;
    i = word_t'(2);
    forever begin
      factor = n - i + word_t'(1);
      prod   = {{DATA_WIDTH{1'b0}}, acc} * {{DATA_WIDTH{1'b0}}, factor};
      acc    = prod[DATA_WIDTH-1:0] / i;
      // a running value of zero stays zero
      if (acc == '0 || i == k) break;
      i++;
    end
    return acc;
  endfunction

  task automatic report_failure(input string what);
    $display("%0t ns  %s", $time, what);
    failures++;
  endtask

  initial begin
    failures = 0;
    pending  = 0;
  end

  always @(posedge clk) begin : watch
    choose_due_t due;
    if (!rst) begin
      // retire before enqueue: a result always belongs to an older request
      if (rsp.valid && rsp.ready) begin
        if (combos_due.size() == 0) begin
          report_failure($sformatf("result %0h with no request outstanding",
                                   rsp.combinations));
        end else begin
          due = combos_due.pop_front();
          if (rsp.combinations !== due.combinations) begin
            report_failure($sformatf("n=%0h k=%0h: combinations %0h, predicted %0h",
                                     due.total_items, due.group_size,
                                     rsp.combinations, due.combinations));
          end
        end
      end
      if (req.valid && req.ready) begin
        due.total_items  = req.total_items;
        due.group_size   = req.group_size;
        due.combinations = wrapped_choose(req.total_items, req.group_size);
        combos_due = {combos_due, due};
      end
      pending = combos_due.size();
    end
  end

endmodule

### bench/tb.sv
// testbench top for binomial_coefficient_iterative_unit: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict
// depends on the rtl, its channel interfaces and bench/bci_result_checker.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH   = 32;
  localparam int STALL_LIMIT  = 50000;
  localparam int ITEMS_PHASE  = 384;

  typedef logic [DATA_WIDTH-1:0] word_t;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;

  bci_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_if ();
  bci_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_if ();

  binomial_coefficient_iterative_unit #(.DATA_WIDTH(DATA_WIDTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  bci_result_checker #(.DATA_WIDTH(DATA_WIDTH)) i_checker (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .failures (failures),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[binomial_coefficient_iterative_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_request(input word_t n, input word_t k);
    int idle;
    idle = 0;
    if (send_idle_pct != 0) begin
      // mostly short gaps, now and then a long one to land in any phase of a pass
      if ($urandom_range(99) < 4) idle = $urandom_range(300, 1);
      else while ($urandom_range(99) < send_idle_pct) idle++;
    end
    if (idle != 0) begin
      req_if.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.total_items <= n;
    req_if.group_size  <= k;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic push_random_request();
    word_t n;
    word_t k;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // group larger than set
      k = $urandom_range(32'hFFFF_FFFF, 1);
      n = $urandom_range(k - 1, 0);
    end else if (pick < 16) begin
      n = $urandom;
      k = $urandom_range(1, 0);
    end else if (pick < 30) begin
      n = $urandom_range(40, 0);
      k = $urandom_range(n + 2, 0);
    end else if (pick < 38) begin
      // many factors of two push the wrapped product toward zero
      n = $urandom << $urandom_range(31, 0);
      k = $urandom_range(24, 2);
    end else if (pick < 42) begin
      n = 32'hFFFF_FFFF - $urandom_range(63, 0);
      k = $urandom_range(12, 2);
    end else begin
      n = $urandom;
      k = $urandom_range(10, 2);
    end
    push_request(n, k);
  endtask

  initial begin
    word_t dir_n[$];
    word_t dir_k[$];
    dir_n = '{32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFE, 32'd1, 32'd2, 32'd5, 32'd5, 32'd10, 32'd30, 32'd40,
              32'h8000_0000, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
              32'h1234_5678, 32'hFFFF_FFFF, 32'd63};
    dir_k = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2,
              32'hFFFF_FFFF, 32'd1, 32'd2, 32'd5, 32'd2, 32'd3, 32'd15, 32'd20,
              32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 32'd5,
              32'h1234_5679, 32'd12, 32'd64};
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.total_items = '0;
    req_if.group_size  = '0;
    send_idle_pct      = 38;
    recv_idle_pct      = 78;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_n[j]) push_request(dir_n[j], dir_k[j]);

    for (int phase = 0; phase < 3; phase++) begin
      // hold the sender until every outstanding result is back
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PHASE) push_random_request();
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("[binomial_coefficient_iterative_unit] OK");
    end else begin
      $display("[binomial_coefficient_iterative_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/bci_pkg.sv
rtl/bci_req_if.sv
rtl/bci_rsp_if.sv
rtl/bci_shared_unit.sv
rtl/binomial_coefficient_iterative_unit.sv
bench/bci_result_checker.sv
bench/tb.sv
